// ===== rtl/rfks_pkg.sv =====
`default_nettype none

package rfks_pkg;

  localparam int MODE_W = 2;
  localparam int KEY_W  = 8;
  localparam int AMT_W  = 16;
  localparam int ST_W   = 2;
  localparam int SEQ_W  = 32;
  localparam int TOT_W  = 20;
  localparam int OCC_W  = 5;

  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QRY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [TOT_W-1:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [SEQ_W-1:0] SEQ_FIRST = 32'd1;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_QRY,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key_code;
    logic [AMT_W-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [SEQ_W-1:0] sequence_number;
    logic [TOT_W-1:0] key_total;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    logic [SEQ_W-1:0] seq;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

`default_nettype wire

// ===== rtl/rfks_ram.sv =====
`default_nettype none

module rfks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rfks_front.sv =====
`default_nettype none

module rfks_front import rfks_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  input  wire logic     cmd_take,
  output cmd_t          cmd
);

  // two-entry command queue between intake and execution
  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    case (in_data.mode)
      MODE_ENQ: cmd_in.op = OP_ENQ;
      MODE_DEQ: cmd_in.op = OP_DEQ;
      MODE_QRY: cmd_in.op = OP_QRY;
      default:  cmd_in.op = OP_NOP;
    endcase
    cmd_in.key    = in_data.key_code;
    cmd_in.amount = in_data.amount;
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfks_back.sv =====
`default_nettype none

module rfks_back import rfks_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  output logic      cmd_take,
  input  wire cmd_t cmd,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata, ram_rdata;
  logic [SLOT_W-1:0] ram_rdata_raw;

  logic [IDX_W:0]   tail_sum;
  logic [IDX_W-1:0] tail;
  logic [TOT_W:0]   add_sum;
  logic [TOT_W-1:0] total_add;
  logic             hit;
  logic             load_out;
  out_item_t        res;

  rfks_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = ram_rdata_raw;

  // head + count stays below twice the depth
  always_comb begin
    tail_sum = {1'b0, head_r} + (IDX_W + 1)'(count_r);
    if (tail_sum >= (IDX_W + 1)'(DEPTH)) begin
      tail = IDX_W'(tail_sum - (IDX_W + 1)'(DEPTH));
    end else begin
      tail = tail_sum[IDX_W-1:0];
    end
  end

  // one compare and add per scanned slot, saturating
  always_comb begin
    hit     = valid_r[scan_r] && (ram_rdata.amount != '0) && (ram_rdata.key == key_r);
    add_sum = {1'b0, total_r} + (TOT_W + 1)'(ram_rdata.amount);
    if (!hit) begin
      total_add = total_r;
    end else if (add_sum > {1'b0, TOTAL_MAX}) begin
      total_add = TOTAL_MAX;
    end else begin
      total_add = add_sum[TOT_W-1:0];
    end
  end

  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    count_nxt        = count_r;
    seq_nxt          = seq_r;
    valid_nxt        = valid_r;
    scan_nxt         = scan_r;
    key_nxt          = key_r;
    total_nxt        = total_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    ram_we           = 1'b0;
    ram_waddr        = tail;
    ram_wdata.key    = cmd.key;
    ram_wdata.amount = cmd.amount;
    ram_wdata.seq    = seq_r;
    ram_raddr        = head_r;
    cmd_take         = 1'b0;
    load_out         = 1'b0;
    res              = '0;
    res.status       = ST_OK;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_take = 1'b1;
          case (cmd.op)
            OP_ENQ: begin
              load_out = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                ram_we          = 1'b1;
                valid_nxt[tail] = 1'b1;
                count_nxt       = count_r + 1'b1;
                seq_nxt         = seq_r + 1'b1;
              end
            end
            OP_DEQ: begin
              if (count_r == '0) begin
                res.status = ST_EMPTY;
                load_out   = 1'b1;
              end else begin
                state_nxt = S_DEQ;
              end
            end
            OP_QRY: begin
              ram_raddr = '0;
              scan_nxt  = '0;
              key_nxt   = cmd.key;
              total_nxt = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        res.sequence_number = ram_rdata.seq;
        valid_nxt[head_r]   = 1'b0;
        head_nxt            = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        count_nxt           = count_r - 1'b1;
        load_out            = 1'b1;
        state_nxt           = S_IDLE;
      end
      S_SCAN: begin
        if (scan_r == IDX_W'(DEPTH - 1)) begin
          res.key_total = total_add;
          load_out      = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ram_raddr = scan_r + 1'b1;
          scan_nxt  = scan_r + 1'b1;
          total_nxt = total_add;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.occupancy = OCC_W'(count_nxt);
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      seq_r       <= SEQ_FIRST;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      seq_r       <= seq_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    key_r      <= key_nxt;
    total_r    <= total_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/ring_fifo_with_key_sum.sv =====
`default_nettype none

// Circular queue of DEPTH order entries (key code, quantity, sequence number)
// with enqueue, dequeue and per-key quantity query; every operation returns
// exactly one result carrying status and occupancy. A two-entry command queue
// takes operations while the executing side is busy. Once an operation reaches
// the executing side, an enqueue or rejected request is answered from the idle
// state, a dequeue reads the head slot and a query adds up matching slots
// before the result register is loaded; all stored entries sit in one RAM with
// a single registered read port, which a query walks one slot per cycle.
module ring_fifo_with_key_sum import rfks_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  rfks_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  rfks_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a rejected enqueue only happens with the queue full
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.occupancy == OCC_W'(DEPTH)))
    else $error("full status with queue not full");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY)
      |-> (out_data.occupancy == '0 && out_data.sequence_number == '0))
    else $error("empty status with entries or a sequence number");

  a_total_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.key_total != '0)
      |-> (out_data.status == ST_OK && out_data.sequence_number == '0))
    else $error("key total reported outside a query");

  // commands are only taken while the result register is free
  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> !out_valid)
    else $error("command taken while a result is pending");

endmodule

`default_nettype wire
